// ===== rtl/ymcr_pkg.sv =====
// Shared types, codes and helper functions for the YMODEM CRC receiver.
`timescale 1ns / 1ps
`default_nettype none
package ymcr_pkg;

    localparam int BUF_ADDR_BITS_DEF = 20;
    localparam int RES_FIFO_DEPTH    = 4;   // power of two, at least 2

    // input actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // finish status
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_IO    = 2'd1;
    localparam logic [1:0] STAT_PROTO = 2'd2;
    localparam logic [1:0] STAT_ABORT = 2'd3;

    // receive phases
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_MARK = 4'd1;
    localparam logic [3:0] PH_SEQ  = 4'd2;
    localparam logic [3:0] PH_INV  = 4'd3;
    localparam logic [3:0] PH_DATA = 4'd4;
    localparam logic [3:0] PH_CRCH = 4'd5;
    localparam logic [3:0] PH_CRCL = 4'd6;
    localparam logic [3:0] PH_EOT2 = 4'd7;
    localparam logic [3:0] PH_CAN2 = 4'd8;

    // session stages
    localparam logic [1:0] ST_HEADER = 2'd0;
    localparam logic [1:0] ST_DATA   = 2'd1;
    localparam logic [1:0] ST_FINAL  = 2'd2;

    // packet roles
    localparam logic [1:0] ROLE_OTHER  = 2'd0;
    localparam logic [1:0] ROLE_HEADER = 2'd1;
    localparam logic [1:0] ROLE_DATA   = 2'd2;
    localparam logic [1:0] ROLE_FINAL  = 2'd3;

    // config register indexes
    localparam logic CFG_RETRY_LIMIT = 1'b0;
    localparam logic CFG_RX_TIMEOUT  = 1'b1;

    // protocol characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_D0  = 8'h30;
    localparam logic [7:0] CH_D9  = 8'h39;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [7:0]  DEF_RETRIES  = 8'd10;
    localparam logic [15:0] DEF_TIMEOUT  = 16'd1000;
    localparam logic [10:0] LEN_SMALL    = 11'd128;
    localparam logic [10:0] LEN_BIG      = 11'd1024;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [7:0]  write_data;
        logic [1:0]  status;
        logic [31:0] file_size;
        logic        last_of_run;
    } t_res;

    function automatic t_res mk_res(logic [1:0] kind, logic [7:0] tx, logic [7:0] data,
                                    logic [1:0] status, logic [31:0] size);
        t_res r;
        r.kind        = kind;
        r.tx_byte     = tx;
        r.write_data  = data;
        r.status      = status;
        r.file_size   = size;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ymcr_if.sv =====
// Valid/ready channel interfaces for the receiver's input and result streams.
`timescale 1ns / 1ps
`default_nettype none
interface ymcr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] rx_byte;
    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface ymcr_out_if #(parameter int ADDR_BITS = 20);
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [7:0]           tx_byte;
    logic [ADDR_BITS-1:0] write_addr;
    logic [7:0]           write_data;
    logic [1:0]           status;
    logic [31:0]          file_size;
    logic                 last_of_run;
    modport source (output valid, output kind, output tx_byte, output write_addr,
                    output write_data, output status, output file_size,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input tx_byte, input write_addr,
                    input write_data, input status, input file_size,
                    input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/ymcr_fifo.sv =====
// Result queue: up to two entries pushed per cycle, one popped.
`timescale 1ns / 1ps
`default_nettype none
module ymcr_fifo
    import ymcr_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = RES_FIFO_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_push_cnt,
    input  wire logic [WIDTH-1:0] i_d0,
    input  wire logic [WIDTH-1:0] i_d1,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_room
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             pop_ok;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_room  = (r_cnt <= CW'(DEPTH - 2));
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_mem[r_wp] <= i_d0;
        if (i_push_cnt == 2'd2) r_mem[r_wp + PW'(1)] <= i_d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_push_cnt);
            r_rp  <= r_rp + PW'(pop_ok);
            r_cnt <= r_cnt + CW'(i_push_cnt) - CW'(pop_ok);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ymcr_core.sv =====
// Protocol engine: framing, CRC, size parse and result generation per event.
`timescale 1ns / 1ps
`default_nettype none
module ymcr_core
    import ymcr_pkg::*;
#(
    parameter int BUF_ADDR_BITS = BUF_ADDR_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_idx,
    input  wire logic [15:0]              i_cfg_data,
    input  wire logic                     i_go,
    input  wire logic [1:0]               i_action,
    input  wire logic [7:0]               i_rx_byte,
    output logic [1:0]                    o_cnt,
    output t_res                          o_res0,
    output t_res                          o_res1,
    output logic [BUF_ADDR_BITS-1:0]      o_addr0
);
    logic [7:0]  r_retry_limit, r_timeout_lo, r_timeout_hi;
    logic [3:0]  r_phase, n_phase;
    logic [1:0]  r_stage, n_stage;
    logic [10:0] r_byte_pos, n_byte_pos;
    logic [7:0]  r_exp_seq, n_exp_seq;
    logic [7:0]  r_pkt_seq, n_pkt_seq;
    logic        r_big, n_big;
    logic [1:0]  r_role, n_role;
    logic [15:0] r_crc_calc, n_crc_calc;
    logic [15:0] r_crc_rx, n_crc_rx;
    logic [31:0] r_bytes_total, n_bytes_total;
    logic [31:0] r_ann, n_ann;
    logic [31:0] r_pend, n_pend;
    logic [1:0]  r_parse, n_parse;
    logic        r_fbz, n_fbz;
    logic        r_allz, n_allz;
    logic [7:0]  r_retries, n_retries;
    logic [15:0] r_idle, n_idle;

    logic [15:0] timeout_reg, limit, idle_inc, crc_full;
    logic [10:0] len;
    logic [32:0] span;
    logic [31:0] copy_len;
    logic [31:0] addr_full;
    logic [1:0]  cnt;
    t_res        res0, res1;
    logic [7:0]  b;

    assign b           = i_rx_byte;
    assign timeout_reg = {r_timeout_hi, r_timeout_lo};
    assign limit       = (timeout_reg != 16'd0) ? timeout_reg : DEF_TIMEOUT;
    assign idle_inc    = (r_idle != 16'hFFFF) ? r_idle + 16'd1 : r_idle;
    assign len         = r_big ? LEN_BIG : LEN_SMALL;
    assign span        = {1'b0, r_bytes_total} + 33'(len);
    assign addr_full   = r_bytes_total + 32'(r_byte_pos);
    assign crc_full    = {r_crc_rx[15:8], b};

    always_comb begin
        if (r_ann != 32'd0 && span > {1'b0, r_ann})
            copy_len = (r_ann >= r_bytes_total) ? r_ann - r_bytes_total : 32'd0;
        else
            copy_len = 32'(len);
    end

    always_comb begin
        n_phase = r_phase;   n_stage = r_stage;     n_byte_pos = r_byte_pos;
        n_exp_seq = r_exp_seq; n_pkt_seq = r_pkt_seq; n_big = r_big;
        n_role = r_role;     n_crc_calc = r_crc_calc; n_crc_rx = r_crc_rx;
        n_bytes_total = r_bytes_total; n_ann = r_ann; n_pend = r_pend;
        n_parse = r_parse;   n_fbz = r_fbz;         n_allz = r_allz;
        n_retries = r_retries; n_idle = r_idle;
        cnt  = 2'd0;
        res0 = mk_res(KIND_SEND, 8'h00, 8'h00, STAT_OK, 32'd0);
        res1 = res0;

        case (i_action)
            ACT_START: begin
                n_phase = PH_MARK;   n_stage = ST_HEADER; n_byte_pos = '0;
                n_exp_seq = '0;      n_pkt_seq = '0;      n_big = 1'b0;
                n_role = ROLE_OTHER; n_crc_calc = '0;     n_crc_rx = '0;
                n_bytes_total = '0;  n_ann = '0;          n_pend = '0;
                n_parse = 2'd0;      n_fbz = 1'b0;        n_allz = 1'b1;
                n_idle = '0;
                n_retries = (r_retry_limit != 8'd0) ? r_retry_limit : DEF_RETRIES;
                cnt  = 2'd1;
                res0 = mk_res(KIND_SEND, CH_C, 8'h00, STAT_OK, 32'd0);
            end
            ACT_BYTE: begin
                if (r_phase != PH_IDLE) begin
                    n_idle = '0;
                    unique case (r_phase)
                        PH_MARK: begin
                            if (b == CH_SOH || b == CH_STX) begin
                                n_big   = (b == CH_STX);
                                n_phase = PH_SEQ;
                            end else if (b == CH_EOT) begin
                                cnt  = 2'd1;
                                res0 = mk_res(KIND_SEND, CH_NAK, 8'h00, STAT_OK, 32'd0);
                                if (r_stage == ST_DATA) n_phase = PH_EOT2;
                            end else if (b == CH_CAN) begin
                                n_phase = PH_CAN2;
                            end
                        end
                        PH_SEQ: begin
                            n_pkt_seq = b;
                            n_phase   = PH_INV;
                        end
                        PH_INV: begin
                            if (8'(r_pkt_seq + b) != 8'hFF) begin
                                cnt     = 2'd1;
                                res0    = mk_res(KIND_SEND, CH_NAK, 8'h00, STAT_OK, 32'd0);
                                n_phase = PH_MARK;
                            end else begin
                                if (r_stage == ST_FINAL && r_pkt_seq == 8'd0)
                                    n_role = ROLE_FINAL;
                                else if (r_stage == ST_HEADER && r_pkt_seq == 8'd0)
                                    n_role = ROLE_HEADER;
                                else if (r_stage == ST_DATA && r_pkt_seq == r_exp_seq)
                                    n_role = ROLE_DATA;
                                else
                                    n_role = ROLE_OTHER;
                                n_byte_pos = '0; n_crc_calc = '0; n_pend = '0;
                                n_parse = 2'd0;  n_fbz = 1'b0;    n_allz = 1'b1;
                                n_phase = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            n_crc_calc = crc_byte(r_crc_calc, b);
                            if (b != 8'd0) n_allz = 1'b0;
                            if (r_byte_pos == 11'd0) n_fbz = (b == 8'd0);
                            // name runs to the first NUL, then decimal size digits
                            if (r_parse == 2'd0) begin
                                if (b == 8'd0) n_parse = 2'd1;
                            end else if (r_parse == 2'd1) begin
                                if (b >= CH_D0 && b <= CH_D9)
                                    n_pend = (r_pend << 3) + (r_pend << 1)
                                           + 32'(b - CH_D0);
                                else
                                    n_parse = 2'd2;
                            end
                            if (r_role == ROLE_DATA && 32'(r_byte_pos) < copy_len) begin
                                cnt  = 2'd1;
                                res0 = mk_res(KIND_WRITE, 8'h00, b, STAT_OK, 32'd0);
                            end
                            n_byte_pos = r_byte_pos + 11'd1;
                            if (n_byte_pos >= len) n_phase = PH_CRCH;
                        end
                        PH_CRCH: begin
                            n_crc_rx = {b, 8'h00};
                            n_phase  = PH_CRCL;
                        end
                        PH_CRCL: begin
                            n_crc_rx = crc_full;
                            n_phase  = PH_MARK;
                            cnt      = 2'd1;
                            res0     = mk_res(KIND_SEND, CH_NAK, 8'h00, STAT_OK, 32'd0);
                            if (crc_full == r_crc_calc) begin
                                case (r_role)
                                    ROLE_FINAL: begin
                                        if (r_allz) begin
                                            cnt  = 2'd2;
                                            res0 = mk_res(KIND_SEND, CH_ACK, 8'h00,
                                                          STAT_OK, 32'd0);
                                            res1 = mk_res(KIND_FINISH, 8'h00, 8'h00,
                                                          STAT_OK, r_ann);
                                            n_phase = PH_IDLE;
                                        end
                                    end
                                    ROLE_HEADER: begin
                                        cnt  = 2'd2;
                                        res0 = mk_res(KIND_SEND, CH_ACK, 8'h00,
                                                      STAT_OK, 32'd0);
                                        if (r_fbz) begin
                                            res1 = mk_res(KIND_FINISH, 8'h00, 8'h00,
                                                          (r_bytes_total != 32'd0) ?
                                                          STAT_OK : STAT_PROTO,
                                                          r_bytes_total);
                                            n_phase = PH_IDLE;
                                        end else begin
                                            res1 = mk_res(KIND_SEND, CH_C, 8'h00,
                                                          STAT_OK, 32'd0);
                                            n_ann         = r_pend;
                                            n_exp_seq     = 8'd1;
                                            n_bytes_total = '0;
                                            n_stage       = ST_DATA;
                                        end
                                    end
                                    ROLE_DATA: begin
                                        n_bytes_total = r_bytes_total + copy_len;
                                        res0 = mk_res(KIND_SEND, CH_ACK, 8'h00,
                                                      STAT_OK, 32'd0);
                                        n_exp_seq = r_exp_seq + 8'd1;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        PH_EOT2: begin
                            n_phase = PH_MARK;
                            if (b == CH_EOT) begin
                                cnt     = 2'd2;
                                res0    = mk_res(KIND_SEND, CH_ACK, 8'h00, STAT_OK, 32'd0);
                                res1    = mk_res(KIND_SEND, CH_C, 8'h00, STAT_OK, 32'd0);
                                n_stage = ST_FINAL;
                            end
                        end
                        PH_CAN2: begin
                            cnt     = 2'd1;
                            res0    = mk_res(KIND_FINISH, 8'h00, 8'h00,
                                             (b == CH_CAN) ? STAT_ABORT : STAT_PROTO,
                                             r_bytes_total);
                            n_phase = PH_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
            ACT_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_idle = idle_inc;
                    if (idle_inc >= limit) begin
                        n_idle = '0;
                        cnt    = 2'd1;
                        res0   = mk_res(KIND_FINISH, 8'h00, 8'h00, STAT_IO, r_bytes_total);
                        n_phase = PH_IDLE;
                        if (r_phase == PH_MARK && r_retries != 8'd0) begin
                            n_retries = r_retries - 8'd1;
                            res0      = mk_res(KIND_SEND, CH_C, 8'h00, STAT_OK, 32'd0);
                            n_phase   = PH_MARK;
                        end else if (r_phase == PH_CAN2) begin
                            res0.status = STAT_ABORT;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (cnt == 2'd1) res0.last_of_run = 1'b1;
        if (cnt == 2'd2) res1.last_of_run = 1'b1;
    end

    assign o_cnt   = i_go ? cnt : 2'd0;
    assign o_res0  = res0;
    assign o_res1  = res1;
    assign o_addr0 = addr_full[BUF_ADDR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= '0;
            r_timeout_lo  <= '0;
            r_timeout_hi  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[7:0];
                CFG_RX_TIMEOUT:  {r_timeout_hi, r_timeout_lo} <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;  r_stage <= ST_HEADER; r_byte_pos <= '0;
            r_exp_seq <= '0;     r_pkt_seq <= '0;      r_big <= 1'b0;
            r_role <= ROLE_OTHER; r_crc_calc <= '0;    r_crc_rx <= '0;
            r_bytes_total <= '0; r_ann <= '0;          r_pend <= '0;
            r_parse <= 2'd0;     r_fbz <= 1'b0;        r_allz <= 1'b1;
            r_retries <= '0;     r_idle <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;  r_stage <= n_stage;   r_byte_pos <= n_byte_pos;
            r_exp_seq <= n_exp_seq; r_pkt_seq <= n_pkt_seq; r_big <= n_big;
            r_role <= n_role;    r_crc_calc <= n_crc_calc; r_crc_rx <= n_crc_rx;
            r_bytes_total <= n_bytes_total; r_ann <= n_ann; r_pend <= n_pend;
            r_parse <= n_parse;  r_fbz <= n_fbz;       r_allz <= n_allz;
            r_retries <= n_retries; r_idle <= n_idle;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ymodem_crc_receiver.sv =====
// Top level of the YMODEM CRC-16 receiver: protocol engine plus result queue.
//
// Usage:
//  - i_in carries events: action 0 starts a session (reply 'C'), action 1 is a
//    received byte, action 2 is a one millisecond tick.
//  - o_out carries results: bytes to send (C/ACK/NAK), payload buffer writes
//    (write_addr/write_data) and a session-finished record with status and size.
//    last_of_run marks the final result of one input event (an event gives 0-2).
//  - Config port (i_cfg_we/i_cfg_idx/i_cfg_data): index 0 retry limit, index 1
//    idle timeout in ms; write only while idle.
// Timing:
//  - Each event is fully processed in the cycle its transfer completes; its
//    results are registered in the result queue and appear on o_out in order.
//  - Throughput: one event per cycle, set by the engine and a four-entry result
//    queue; i_in.ready drops while fewer than two entries are free, i.e. when
//    the receiver of o_out stalls long enough to fill it.
// Reset: synchronous, active low; clears the session (phase idle), both config
//  registers and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module ymodem_crc_receiver
    import ymcr_pkg::*;
#(
    parameter int BUF_ADDR_BITS = BUF_ADDR_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    ymcr_in_if.sink          i_in,
    ymcr_out_if.source       o_out
);
    localparam int QW = $bits(t_res) + BUF_ADDR_BITS;

    logic                     room, go;
    logic [1:0]               push_cnt;
    t_res                     res0, res1, head;
    logic [BUF_ADDR_BITS-1:0] addr0, head_addr;
    logic [QW-1:0]            q_head;

    // accept an event only if both possible results fit in the queue
    assign i_in.ready = room;
    assign go         = i_in.valid && room;

    ymcr_core #(.BUF_ADDR_BITS(BUF_ADDR_BITS)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_go       (go),
        .i_action   (i_in.action),
        .i_rx_byte  (i_in.rx_byte),
        .o_cnt      (push_cnt),
        .o_res0     (res0),
        .o_res1     (res1),
        .o_addr0    (addr0)
    );

    // only the first result of an event can be a buffer write
    ymcr_fifo #(.WIDTH(QW), .DEPTH(RES_FIFO_DEPTH)) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_d0       ({res0, addr0}),
        .i_d1       ({res1, {BUF_ADDR_BITS{1'b0}}}),
        .i_pop      (o_out.ready),
        .o_valid    (o_out.valid),
        .o_data     (q_head),
        .o_room     (room)
    );

    assign {head, head_addr} = q_head;
    assign o_out.kind        = head.kind;
    assign o_out.tx_byte     = head.tx_byte;
    assign o_out.write_addr  = (head.kind == KIND_WRITE) ? head_addr : '0;
    assign o_out.write_data  = head.write_data;
    assign o_out.status      = head.status;
    assign o_out.file_size   = head.file_size;
    assign o_out.last_of_run = head.last_of_run;
endmodule
`default_nettype wire

// ===== rtl/ymcr_checker.sv =====
// Port-level assertions for the receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ymcr_checker
    import ymcr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic [1:0]  i_in_action,
    input wire logic        i_out_valid,
    input wire logic [1:0]  i_out_kind,
    input wire logic [7:0]  i_out_tx,
    input wire logic [1:0]  i_out_status
);
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending right after reset");

    a_start_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_action == ACT_START) |=> i_out_valid)
        else $error("start transfer produced no reply");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind == KIND_SEND || i_out_kind == KIND_WRITE ||
                         i_out_kind == KIND_FINISH))
        else $error("illegal result kind");

    a_send_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind == KIND_SEND) |->
        ((i_out_tx == CH_C || i_out_tx == CH_ACK || i_out_tx == CH_NAK) &&
         i_out_status == STAT_OK))
        else $error("bad reply byte");
endmodule

bind ymodem_crc_receiver ymcr_checker u_ymcr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_action  (i_in.action),
    .i_out_valid  (o_out.valid),
    .i_out_kind   (o_out.kind),
    .i_out_tx     (o_out.tx_byte),
    .i_out_status (o_out.status)
);
`default_nettype wire
